// File: rtl/bmqb_pkg.sv
// Package for the bounded message queue bank.
// Holds field widths, operation and register codes, FSM and command types.
// No dependencies.
package bmqb_pkg;

    localparam int NUM_QUEUES_DEF  = 4;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ITEM_BYTES_DEF  = 8;

    localparam int FUNC_W     = 2;
    localparam int HANDLE_W   = 2;
    localparam int ITEM_W     = 64;
    localparam int FILL_W     = 5;
    localparam int QCOUNT_W   = 3;
    localparam int CAP_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;
    localparam int NUM_CAPS   = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [FUNC_W-1:0] FUNC_SEND  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RECV  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_Q0      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_Q1      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_Q2      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_Q3      = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctrl_cmd_t;

endpackage

// File: rtl/bmqb_ifs.sv
// Channel interfaces: request, response and configuration write.
// Depends on bmqb_pkg.
interface bmqb_req_if;
    logic                          valid;
    logic                          ready;
    logic [bmqb_pkg::FUNC_W-1:0]   func;
    logic [bmqb_pkg::HANDLE_W-1:0] handle;
    logic [bmqb_pkg::ITEM_W-1:0]   item_in;
    modport source (output valid, func, handle, item_in, input ready);
    modport sink   (input valid, func, handle, item_in, output ready);
endinterface

interface bmqb_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        ok;
    logic [bmqb_pkg::ITEM_W-1:0] item_out;
    logic [bmqb_pkg::FILL_W-1:0] fill_count;
    modport source (output valid, ok, item_out, fill_count, input ready);
    modport sink   (input valid, ok, item_out, fill_count, output ready);
endinterface

interface bmqb_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [bmqb_pkg::CFG_IDX_W-1:0]  index;
    logic [bmqb_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/bmqb_ctrl.sv
// Controller FSM: accept, execute, respond.
// Depends on bmqb_pkg.
module bmqb_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output bmqb_pkg::ctrl_cmd_t cmd
);

    bmqb_pkg::state_t state_reg;
    bmqb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bmqb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bmqb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bmqb_pkg::ST_EXEC;
                end
            end
            bmqb_pkg::ST_EXEC:
            begin
                state_next = bmqb_pkg::ST_RESP;
            end
            bmqb_pkg::ST_RESP:
            begin
                if (out_ready)
                begin
                    state_next = bmqb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bmqb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        case (state_reg)
            bmqb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            bmqb_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            bmqb_pkg::ST_RESP:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/bmqb_dp.sv
// Datapath: configuration registers, queue pointers, item memory, result registers.
// Depends on bmqb_pkg.
module bmqb_dp
#(
    parameter int NUM_QUEUES  = bmqb_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = bmqb_pkg::QUEUE_DEPTH_DEF,
    parameter int ITEM_BYTES  = bmqb_pkg::ITEM_BYTES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  bmqb_pkg::ctrl_cmd_t             cmd,
    input  logic [bmqb_pkg::FUNC_W-1:0]     func,
    input  logic [bmqb_pkg::HANDLE_W-1:0]   handle,
    input  logic [bmqb_pkg::ITEM_W-1:0]     item_in,
    output logic                            ok,
    output logic [bmqb_pkg::ITEM_W-1:0]     item_out,
    output logic [bmqb_pkg::FILL_W-1:0]     fill_count,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bmqb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bmqb_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int IW       = 8 * ITEM_BYTES;
    localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FI_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W    = FI_W + 1;
    localparam int FX_W     = (FI_W > bmqb_pkg::FILL_W) ? FI_W : bmqb_pkg::FILL_W;
    localparam int Q_W      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int HQ_W     = (Q_W > bmqb_pkg::HANDLE_W) ? Q_W : bmqb_pkg::HANDLE_W;
    localparam int ENTRIES  = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [bmqb_pkg::FUNC_W-1:0]   func_reg;
    logic [bmqb_pkg::HANDLE_W-1:0] handle_reg;
    logic [IW-1:0]                 item_reg;

    logic [bmqb_pkg::QCOUNT_W-1:0] qcount_reg;
    logic [bmqb_pkg::CAP_W-1:0]    cap_reg [bmqb_pkg::NUM_CAPS];

    logic [PTR_W-1:0] head_reg [NUM_QUEUES];
    logic [FI_W-1:0]  fill_reg [NUM_QUEUES];

    logic [IW-1:0]    mem [ENTRIES];
    logic [IW-1:0]    rdata_reg;

    logic                        ok_reg;
    logic                        recv_reg;
    logic [bmqb_pkg::FILL_W-1:0] fill_out_reg;

    logic [HQ_W-1:0]             q_wide;
    logic [Q_W-1:0]              q_idx;
    logic                        op_valid;
    logic [PTR_W-1:0]            cur_head;
    logic [FI_W-1:0]             cur_fill;
    logic [bmqb_pkg::CAP_W-1:0]  cap_sel;
    logic                        do_send;
    logic                        do_recv;
    logic [SUM_W-1:0]            sum;
    logic [PTR_W-1:0]            slot;
    logic [PTR_W-1:0]            nxt_head;
    logic [FI_W-1:0]             new_fill;
    logic [FX_W-1:0]             fill_x;
    logic [ADDR_W-1:0]           addr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qcount_reg <= '0;
            for (int i = 0; i < bmqb_pkg::NUM_CAPS; i++)
            begin
                cap_reg[i] <= bmqb_pkg::CAP_RESET;
            end
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bmqb_pkg::REG_QUEUE_COUNT: qcount_reg <= cfg_data[bmqb_pkg::QCOUNT_W-1:0];
                bmqb_pkg::REG_CAP_Q0:      cap_reg[0] <= cfg_data;
                bmqb_pkg::REG_CAP_Q1:      cap_reg[1] <= cfg_data;
                bmqb_pkg::REG_CAP_Q2:      cap_reg[2] <= cfg_data;
                bmqb_pkg::REG_CAP_Q3:      cap_reg[3] <= cfg_data;
                default:                   qcount_reg <= qcount_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= func;
            handle_reg <= handle;
            item_reg   <= item_in[IW-1:0];
        end
    end

    always_comb
    begin
        q_wide   = HQ_W'(handle_reg);
        q_idx    = q_wide[Q_W-1:0];
        op_valid = (handle_reg < qcount_reg) && (32'(handle_reg) < NUM_QUEUES)
                   && ((func_reg == bmqb_pkg::FUNC_SEND) || (func_reg == bmqb_pkg::FUNC_RECV)
                       || (func_reg == bmqb_pkg::FUNC_QUERY));
        cur_head = head_reg[q_idx];
        cur_fill = fill_reg[q_idx];
        cap_sel  = cap_reg[handle_reg];
        do_send  = op_valid && (func_reg == bmqb_pkg::FUNC_SEND)
                   && (32'(cur_fill) < 32'(cap_sel)) && (32'(cur_fill) < QUEUE_DEPTH);
        do_recv  = op_valid && (func_reg == bmqb_pkg::FUNC_RECV) && (cur_fill != '0);
        sum      = SUM_W'(cur_head) + SUM_W'(cur_fill);
        if (sum >= SUM_W'(QUEUE_DEPTH))
        begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        slot     = do_send ? sum[PTR_W-1:0] : cur_head;
        nxt_head = (32'(cur_head) == QUEUE_DEPTH - 1) ? '0 : cur_head + PTR_W'(1);
        new_fill = cur_fill;
        if (do_send)
        begin
            new_fill = cur_fill + FI_W'(1);
        end
        else if (do_recv)
        begin
            new_fill = cur_fill - FI_W'(1);
        end
        fill_x   = op_valid ? FX_W'(new_fill) : '0;
        addr     = ADDR_W'(32'(q_idx) * QUEUE_DEPTH + 32'(slot));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end
        else if (cmd.exec && (do_send || do_recv))
        begin
            fill_reg[q_idx] <= new_fill;
            if (do_recv)
            begin
                head_reg[q_idx] <= nxt_head;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && do_send)
        begin
            mem[addr] <= item_reg;
        end
        if (cmd.exec && do_recv)
        begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            ok_reg       <= do_send || do_recv || (op_valid && (func_reg == bmqb_pkg::FUNC_QUERY));
            recv_reg     <= do_recv;
            fill_out_reg <= fill_x[bmqb_pkg::FILL_W-1:0];
        end
    end

    assign ok         = ok_reg;
    assign item_out   = recv_reg ? bmqb_pkg::ITEM_W'(rdata_reg) : '0;
    assign fill_count = fill_out_reg;

endmodule

// File: rtl/bounded_message_queue_bank_top.sv
// Top level of the bounded message queue bank: controller plus datapath.
// A request passes through the controller's execute state, where the datapath registers
// its result; the response is then presented in the respond state and held until taken.
// One request at a time: a new request is accepted only after the response is taken,
// as set by the controller's accept, execute and respond states.
// Reset clears queue pointers and fill levels and restores the register defaults;
// the item memory is not cleared and needs no clearing pass.
module bounded_message_queue_bank_top
#(
    parameter int NUM_QUEUES  = bmqb_pkg::NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = bmqb_pkg::QUEUE_DEPTH_DEF,
    parameter int ITEM_BYTES  = bmqb_pkg::ITEM_BYTES_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    bmqb_req_if.sink   req,
    bmqb_rsp_if.source rsp,
    bmqb_cfg_if.sink   cfg
);

    bmqb_pkg::ctrl_cmd_t cmd;

    bmqb_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    bmqb_dp
    #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ITEM_BYTES  (ITEM_BYTES)
    )
    u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .func       (req.func),
        .handle     (req.handle),
        .item_in    (req.item_in),
        .ok         (rsp.ok),
        .item_out   (rsp.item_out),
        .fill_count (rsp.fill_count),
        .cfg_valid  (cfg.valid),
        .cfg_ready  (cfg.ready),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data)
    );

endmodule

// File: rtl/bmqb_checker.sv
// Port-level checker for the bounded message queue bank, with its bind.
// Depends on bmqb_pkg and bounded_message_queue_bank_top.
module bmqb_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic                        rsp_ok,
    input logic [bmqb_pkg::ITEM_W-1:0] rsp_item_out,
    input logic [bmqb_pkg::FILL_W-1:0] rsp_fill_count
);

    logic req_xact;
    assign req_xact = req_valid && req_ready;

    // one transaction in flight: request ready drops once a request is taken
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        req_xact |=> !req_ready)
        else $error("request taken while another is in flight");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_xact |=> ##1 rsp_valid)
        else $error("response not shown two cycles after request");

    a_fail_item: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ok) |-> (rsp_item_out == '0))
        else $error("failed operation returned an item");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_ok) && $stable(rsp_item_out) && $stable(rsp_fill_count)))
        else $error("stalled response changed");

endmodule

bind bounded_message_queue_bank_top bmqb_checker u_bmqb_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_ok         (rsp.ok),
    .rsp_item_out   (rsp.item_out),
    .rsp_fill_count (rsp.fill_count)
);
